### src/cpg_pkg.sv
// cpg_pkg: widths, limits and types shared by the circle point generator
// depends on nothing; imported by circle_point_generator
package cpg_pkg;

  // limits of the walk
  localparam int MAX_RADIUS  = 32;
  localparam int MAX_RESULTS = 50;
  localparam int MAX_STEPS   = MAX_RESULTS / 2;
  localparam int STEP_W      = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

  // field widths
  localparam int CRD_W      = 8;
  localparam int RAD_W      = 6;
  localparam int PT_W       = 10;
  localparam int D_W        = 10;
  localparam int OFS_W      = RAD_W + 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8 * PT_W;

  // decision value constants
  localparam int D_INIT     = 3;
  localparam int D_INC_KEEP = 6;
  localparam int D_INC_STEP = 10;

  typedef logic signed [OFS_W-1:0] ofs_t;
  typedef logic signed [PT_W-1:0]  pt_t;
  typedef logic signed [D_W-1:0]   dec_t;

endpackage

### src/circle_point_generator.sv
// circle_point_generator: midpoint circle walk, four mirrored points per result
// depends on cpg_pkg
// the first result is loaded into the output register from S_HALF0, the state entered when the request is taken
// throughput: one result per cycle while the output is not stalled, two per walk step;
//   a circle of radius 32 takes 23 walk steps; the rate is set by the one result the
//   shared point adders form per cycle
// a new request is taken only when the walk has finished
// reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid
module circle_point_generator
  import cpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // center_x [7:0], center_y [15:8], radius [21:16]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y, point_d_x,
  // point_d_y, 10 bits each from bit 0 up
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast   // last_group
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HALF0,
    S_HALF1
  } state_t;

  state_t                  state_r;
  logic                    out_valid_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic                    out_last_r;
  logic [CRD_W-1:0]        cx_r, cy_r;
  ofs_t                    x_r, y_r;
  dec_t                    d_r;
  logic [STEP_W-1:0]       steps_r;

  logic [RAD_W-1:0]        rad_in, rad_sat;
  ofs_t                    minor_s, major_s;
  pt_t                     minor_e, major_e, cx_e, cy_e;
  pt_t                     px, qx, py, qy;
  logic                    load_s;
  ofs_t                    x_nxt, y_nxt;
  dec_t                    xd, yd, d_nxt;
  logic                    cont_s;

  // no request is taken while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // radius saturation on the request
  assign rad_in  = in_tdata[21:16];
  assign rad_sat = (rad_in > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_in;

  // shared point adders, offsets swapped on the second half-step
  assign minor_s = (state_r == S_HALF1) ? y_r : x_r;
  assign major_s = (state_r == S_HALF1) ? x_r : y_r;
  assign minor_e = {{(PT_W-OFS_W){minor_s[OFS_W-1]}}, minor_s};
  assign major_e = {{(PT_W-OFS_W){major_s[OFS_W-1]}}, major_s};
  assign cx_e    = {{(PT_W-CRD_W){1'b0}}, cx_r};
  assign cy_e    = {{(PT_W-CRD_W){1'b0}}, cy_r};
  assign px      = cx_e + minor_e;
  assign qx      = cx_e - minor_e;
  assign py      = cy_e + major_e;
  assign qy      = cy_e - major_e;

  // decision update and loop test for the end of a walk step
  assign xd    = {{(D_W-OFS_W){x_r[OFS_W-1]}}, x_r};
  assign yd    = {{(D_W-OFS_W){y_r[OFS_W-1]}}, y_r};
  assign x_nxt = x_r + ofs_t'(1);
  assign y_nxt = d_r[D_W-1] ? y_r : (y_r - ofs_t'(1));
  assign d_nxt = d_r[D_W-1] ? (d_r + (xd <<< 2) + dec_t'(D_INC_KEEP))
                            : (d_r + ((xd - yd) <<< 2) + dec_t'(D_INC_STEP));
  assign cont_s = (x_nxt <= y_nxt) && (steps_r != STEP_W'(MAX_STEPS - 1));

  // a result moves into the output register when it is empty or being drained
  assign load_s = (state_r != S_IDLE) && (!out_valid_r || out_tready);

  // sequencer, walk state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !load_s) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cx_r    <= in_tdata[7:0];
            cy_r    <= in_tdata[15:8];
            x_r     <= '0;
            y_r     <= {1'b0, rad_sat};
            d_r     <= dec_t'(D_INIT) - dec_t'({{(D_W-RAD_W-1){1'b0}}, rad_sat, 1'b0});
            steps_r <= '0;
            state_r <= S_HALF0;
          end
        end
        S_HALF0: begin
          if (load_s) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {qy, qx, qy, px, py, qx, py, px};
            out_last_r  <= 1'b0;
            state_r     <= S_HALF1;
          end
        end
        S_HALF1: begin
          if (load_s) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {qy, qx, qy, px, py, qx, py, px};
            out_last_r  <= !cont_s;
            x_r         <= x_nxt;
            y_r         <= y_nxt;
            d_r         <= d_nxt;
            steps_r     <= steps_r + STEP_W'(1);
            state_r     <= cont_s ? S_HALF0 : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/testbench.sv
// testbench for circle_point_generator: random and directed circle requests with
// a self-checking walk predictor; both stream sides idle at random
// depends on cpg_pkg and circle_point_generator
module testbench
  import cpg_pkg::*;
();

  // predicted point groups of every accepted circle, oldest first
  class circle_scoreboard;
    logic [OUT_DATA_W-1:0] group_points[$];
    logic                  group_last[$];
    int                    errors = 0;
    string                 field_names[8] = '{"point_a_x", "point_a_y", "point_b_x",
                                              "point_b_y", "point_c_x", "point_c_y",
                                              "point_d_x", "point_d_y"};

    // walk one octant and queue two mirrored groups per step
    function void note_request(logic [CRD_W-1:0] cx, logic [CRD_W-1:0] cy,
                               logic [RAD_W-1:0] rad);
      int icx, icy, r, x, y, d, n, half;
      int px, py, qx, qy;
      icx = int'(cx);
      icy = int'(cy);
      r = (int'(rad) > MAX_RADIUS) ? MAX_RADIUS : int'(rad);
      x = 0;
      y = r;
      d = D_INIT - 2 * r;
      n = 0;
      while (x <= y && n + 2 <= MAX_RESULTS) begin
        for (half = 0; half < 2; half++) begin
          if (half == 0) begin
            px = icx + x; py = icy + y; qx = icx - x; qy = icy - y;
          end else begin
            px = icx + y; py = icy + x; qx = icx - y; qy = icy - x;
          end
          // a_x sits in the lowest bits, d_y in the highest
          group_points.push_back({pt_t'(qy), pt_t'(qx), pt_t'(qy), pt_t'(px),
                                  pt_t'(py), pt_t'(qx), pt_t'(py), pt_t'(px)});
          group_last.push_back(1'b0);
          n++;
        end
        if (d < 0) begin
          d += 4 * x + D_INC_KEEP;
        end else begin
          d += 4 * (x - y) + D_INC_STEP;
          y--;
        end
        x++;
      end
      if (n > 0) group_last[$] = 1'b1;
    endfunction

    function int outstanding();
      return group_points.size();
    endfunction

    // compare one accepted group with the oldest prediction
    function void check_group(logic [OUT_DATA_W-1:0] points, logic last);
      logic [OUT_DATA_W-1:0] want;
      logic                  want_last;
      int                    i;
      if (group_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected group, expected none, actual %h last %b",
                 $time, points, last);
        return;
      end
      want = group_points.pop_front();
      want_last = group_last.pop_front();
      for (i = 0; i < 8; i++) begin
        if (points[i*PT_W +: PT_W] !== want[i*PT_W +: PT_W]) begin
          errors++;
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                   field_names[i], $signed(want[i*PT_W +: PT_W]),
                   $signed(points[i*PT_W +: PT_W]));
        end
      end
      if (last !== want_last) begin
        errors++;
        $display("%0t: last_group mismatch, expected %b, actual %b",
                 $time, want_last, last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  circle_scoreboard circles = new();
  bit               no_idle = 1'b0;

  circle_point_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one circle request, held until accepted; valid stays high across back-to-back requests
  task automatic send_circle(input logic [CRD_W-1:0] cx, input logic [CRD_W-1:0] cy,
                             input logic [RAD_W-1:0] rad);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - RAD_W - 2*CRD_W){1'b0}}, rad, cy, cx};
    do @(posedge clk); while (!in_tready);
    circles.note_request(cx, cy, rad);
  endtask

  task automatic drain_circles();
    while (circles.outstanding() != 0) @(posedge clk);
  endtask

  // result side: random stall before each group
  initial begin
    int stall;
    @(posedge clk iff rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      circles.check_group(out_tdata, out_tlast);
    end
  end

  // stimulus and end of run
  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero radius, full radius, saturation, corner centers, bit patterns
    send_circle(8'd0,   8'd0,   6'd0);
    send_circle(8'd255, 8'd255, 6'd0);
    send_circle(8'd0,   8'd0,   6'd32);
    send_circle(8'd255, 8'd255, 6'd32);
    send_circle(8'd0,   8'd255, 6'd1);
    send_circle(8'd255, 8'd0,   6'd2);
    send_circle(8'd100, 8'd50,  6'd3);
    send_circle(8'd7,   8'd200, 6'd31);
    send_circle(8'd128, 8'd128, 6'd33);
    send_circle(8'd64,  8'd192, 6'd63);
    send_circle(8'd170, 8'd85,  6'd21);
    send_circle(8'd85,  8'd170, 6'd42);
    send_circle(8'd0,   8'd0,   6'd63);
    send_circle(8'd200, 8'd30,  6'd5);
    send_circle(8'd1,   8'd2,   6'd10);

    // hold off until the block has emptied
    in_tvalid <= 1'b0;
    drain_circles();

    // random: idle phase, back-to-back phase, idle phase; occasional drains in both idle phases
    for (i = 0; i < 210; i++) begin
      no_idle = (i >= 70 && i < 140);
      if (!no_idle && $urandom_range(0, 19) == 0) begin
        in_tvalid <= 1'b0;
        drain_circles();
      end
      if ($urandom_range(0, 3) == 0)
        send_circle(CRD_W'($urandom_range(0, 255)), CRD_W'($urandom_range(0, 255)),
                    RAD_W'($urandom_range(0, 4)));
      else
        send_circle(CRD_W'($urandom_range(0, 255)), CRD_W'($urandom_range(0, 255)),
                    RAD_W'($urandom_range(0, 63)));
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    drain_circles();
    repeat (20) @(posedge clk);
    if (circles.errors == 0 && circles.outstanding() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // run limit
  initial begin
    #40000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
